### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, cond) \
	`ASSERT_PROP(label, !(cond))

`endif

### design/epd_pkg.sv
// ---------------------------------------------------------------------------
// epd_pkg
// widths, constants and codes of the endless pot position decoder
// ---------------------------------------------------------------------------
package epd_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int DEADBAND_W = 8;
	localparam int TURN_W     = 19;
	localparam int POS_W      = 32;
	localparam int TURN_SHIFT = 13;
	localparam int BLEND_SHIFT = 11;
	localparam int VA_W       = 14;
	localparam int VB_W       = 13;
	localparam int PROD_A_W   = VA_W + SAMPLE_W;
	localparam int PROD_B_W   = VB_W + SAMPLE_W;
	localparam int SUM_W      = PROD_A_W + 1;
	localparam int BLEND_W    = SUM_W - BLEND_SHIFT;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 64;

	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 8'd10;
	localparam logic [SAMPLE_W-1:0]   MID_SCALE      = 12'd2048;
	localparam logic [VA_W-1:0]       FULL_TURN      = 14'd8192;
	localparam logic [VB_W-1:0]       VB_OFFSET      = 13'd2048;

	typedef logic [1:0] sector_t;

	// quadrant codes, clockwise
	localparam sector_t SECTOR_0 = 2'd0;
	localparam sector_t SECTOR_1 = 2'd1;
	localparam sector_t SECTOR_2 = 2'd2;
	localparam sector_t SECTOR_3 = 2'd3;

endpackage

### design/endless_pot_position_decoder_top.sv
// ---------------------------------------------------------------------------
// endless_pot_position_decoder_top
// Turns 12-bit sample pairs from the two wipers of an endless potentiometer
// into an absolute knob position of 8192 counts per turn. Each wiper sample
// passes a deadband lag filter (threshold set by cfg_wdata, reset 10); when
// either filtered value moves, the quadrant, whole-turn count and blended
// position are recomputed. Every input word yields exactly one output word:
// the updated flag in m_tuser, then position and the delta of the last
// recomputation in m_tdata. Position and turn count wrap in two's
// complement. One word is taken per clock unless s_tready is low. There
// are two registers, an input register and the result register, with the
// filter, sector, turn count, both blend multipliers and the position sum
// in one combinational pass between them: an accepted word moves into the
// result register once that register is empty or draining, and is offered
// on m_tdata from then on. s_tready drops only while both registers hold a
// word and m_tready is low. The filter and turn state close their loop in
// that single pass, so back-to-back words always see the state left by the
// one before.
// Write the deadband only while no words are in flight.
// ---------------------------------------------------------------------------
module endless_pot_position_decoder_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// deadband register write
	input  logic                                   cfg_we,
	input  logic [epd_pkg::DEADBAND_W-1:0]         cfg_wdata,
	// sample pair stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [epd_pkg::IN_DATA_W-1:0]          s_tdata,  // wiper_a_sample, wiper_b_sample
	// position stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [epd_pkg::OUT_DATA_W-1:0]         m_tdata,  // position, delta
	output logic                                   m_tuser   // updated
);

	// filter result for one wiper
	typedef struct packed {
		logic                          changed;
		logic [epd_pkg::SAMPLE_W-1:0]  value;
	} lag_t;

	function automatic lag_t lag_filter(
		input logic [epd_pkg::SAMPLE_W-1:0]   sample,
		input logic [epd_pkg::SAMPLE_W-1:0]   smooth,
		input logic [epd_pkg::DEADBAND_W-1:0] db
	);
		logic                         above;
		logic [epd_pkg::SAMPLE_W-1:0] diff;
		logic [epd_pkg::SAMPLE_W-1:0] db_ext;
		lag_t                         res;
		above  = sample > smooth;
		diff   = above ? (sample - smooth) : (smooth - sample);
		db_ext = {{(epd_pkg::SAMPLE_W-epd_pkg::DEADBAND_W){1'b0}}, db};
		res.changed = diff > db_ext;
		// follow to within deadband of the sample; cannot underflow when above
		if (res.changed) begin
			res.value = above ? (sample - db_ext) : sample;
		end else begin
			res.value = smooth;
		end
		return res;
	endfunction

	// configuration
	logic [epd_pkg::DEADBAND_W-1:0] deadband_q;

	// decoder state
	logic [epd_pkg::SAMPLE_W-1:0] smooth_a_q;
	logic [epd_pkg::SAMPLE_W-1:0] smooth_b_q;
	epd_pkg::sector_t             last_sector_q;
	logic [epd_pkg::TURN_W-1:0]   turn_q;

	// stage 1: input register
	logic                         valid_s1;
	logic [epd_pkg::SAMPLE_W-1:0] a_s1;
	logic [epd_pkg::SAMPLE_W-1:0] b_s1;

	// result register; position and delta double as decoder state
	logic                         out_valid_q;
	logic                         updated_q;
	logic [epd_pkg::POS_W-1:0]    position_q;
	logic [epd_pkg::POS_W-1:0]    delta_q;

	// flow control: a register loads when it is empty or draining
	logic adv_out;
	logic fire1;

	assign adv_out  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_out;
	assign fire1    = valid_s1 && adv_out;

	// single pass: filter, sector, turns, blend and position
	lag_t                         lag_a;
	lag_t                         lag_b;
	logic                         upd;
	logic                         a_hi;
	logic                         b_hi;
	epd_pkg::sector_t             sector;
	logic [epd_pkg::TURN_W-1:0]   turn_nxt;
	logic [epd_pkg::VA_W-1:0]     va;
	logic [epd_pkg::VB_W-1:0]     vb;
	logic [epd_pkg::SAMPLE_W-1:0] ratio;
	logic [epd_pkg::SAMPLE_W-1:0] weight;
	logic [epd_pkg::PROD_A_W-1:0] prod_a;
	logic [epd_pkg::PROD_B_W-1:0] prod_b;
	logic [epd_pkg::SUM_W-1:0]    blend_sum;
	logic [epd_pkg::BLEND_W-1:0]  blend;
	logic [epd_pkg::POS_W-1:0]    pos_nxt;

	always_comb begin
		lag_a = lag_filter(a_s1, smooth_a_q, deadband_q);
		lag_b = lag_filter(b_s1, smooth_b_q, deadband_q);
		upd   = lag_a.changed || lag_b.changed;

		// raw code {b_hi, a_hi} with the two upper codes swapped
		a_hi   = lag_a.value > epd_pkg::MID_SCALE;
		b_hi   = lag_b.value > epd_pkg::MID_SCALE;
		sector = {b_hi, a_hi ^ b_hi};

		// whole turns counted on wraps across the sector 3 / sector 0 edge
		turn_nxt = turn_q;
		if (last_sector_q == epd_pkg::SECTOR_0 && sector == epd_pkg::SECTOR_3) begin
			turn_nxt = turn_q - {{(epd_pkg::TURN_W-1){1'b0}}, 1'b1};
		end else if (last_sector_q == epd_pkg::SECTOR_3 && sector == epd_pkg::SECTOR_0) begin
			turn_nxt = turn_q + {{(epd_pkg::TURN_W-1){1'b0}}, 1'b1};
		end

		// wiper a mirrored in the upper half turn
		if (sector == epd_pkg::SECTOR_2 || sector == epd_pkg::SECTOR_3) begin
			va = epd_pkg::FULL_TURN - {2'b00, lag_a.value};
		end else begin
			va = {2'b00, lag_a.value};
		end

		// wiper b folded around mid scale, modulo one turn
		if (sector == epd_pkg::SECTOR_0 || sector == epd_pkg::SECTOR_3) begin
			vb = epd_pkg::VB_OFFSET - {1'b0, lag_b.value};
		end else begin
			vb = {1'b0, lag_b.value} + epd_pkg::VB_OFFSET;
		end

		// distance of wiper a from mid scale, 0..2048
		if (lag_a.value >= epd_pkg::MID_SCALE) begin
			ratio = lag_a.value - epd_pkg::MID_SCALE;
		end else begin
			ratio = epd_pkg::MID_SCALE - lag_a.value;
		end
		weight = epd_pkg::MID_SCALE - ratio;

		prod_a = {{epd_pkg::SAMPLE_W{1'b0}}, va} * {{epd_pkg::VA_W{1'b0}}, weight};
		prod_b = {{epd_pkg::SAMPLE_W{1'b0}}, vb} * {{epd_pkg::VB_W{1'b0}}, ratio};

		// final blend and position
		blend_sum = {1'b0, prod_a} + {2'b00, prod_b};
		blend     = blend_sum[epd_pkg::SUM_W-1:epd_pkg::BLEND_SHIFT];
		pos_nxt   = {turn_nxt, {epd_pkg::TURN_SHIFT{1'b0}}}
			+ {{(epd_pkg::POS_W-epd_pkg::BLEND_W){1'b0}}, blend};
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q    <= epd_pkg::DEADBAND_RESET;
			smooth_a_q    <= '0;
			smooth_b_q    <= '0;
			last_sector_q <= epd_pkg::SECTOR_0;
			turn_q        <= '0;
			position_q    <= '0;
			delta_q       <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				deadband_q <= cfg_wdata;
			end

			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end

			// all decoder state moves as the word leaves the input register
			if (fire1) begin
				smooth_a_q <= lag_a.value;
				smooth_b_q <= lag_b.value;
				if (upd) begin
					last_sector_q <= sector;
					turn_q        <= turn_nxt;
					// prior position is the old position_q, so delta is formed here
					position_q    <= pos_nxt;
					delta_q       <= pos_nxt - position_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			a_s1 <= s_tdata[epd_pkg::SAMPLE_W-1:0];
			b_s1 <= s_tdata[2*epd_pkg::SAMPLE_W-1:epd_pkg::SAMPLE_W];
		end
		if (fire1) begin
			updated_q <= upd;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = updated_q;
	assign m_tdata  = {delta_q, position_q};

endmodule

### design/epd_checker.sv
// ---------------------------------------------------------------------------
// epd_checker
// port-level checks of the endless pot position decoder
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module epd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [epd_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	logic [2:0]                    in_flight_q;
	logic [epd_pkg::POS_W-1:0]     last_pos_q;
	logic [epd_pkg::POS_W-1:0]     last_delta_q;
	logic                          in_fire;
	logic                          out_fire;
	logic [epd_pkg::POS_W-1:0]     pos;
	logic [epd_pkg::POS_W-1:0]     delta;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign pos      = m_tdata[epd_pkg::POS_W-1:0];
	assign delta    = m_tdata[epd_pkg::OUT_DATA_W-1:epd_pkg::POS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q  <= '0;
			last_pos_q   <= '0;
			last_delta_q <= '0;
		end else begin
			in_flight_q <= in_flight_q + {2'b00, in_fire} - {2'b00, out_fire};
			if (out_fire) begin
				last_pos_q   <= pos;
				last_delta_q <= delta;
			end
		end
	end

	// stalled word holds
	`ASSERT_PROP(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// no word delivered without one taken in
	`ASSERT_NEVER(a_no_invent, m_tvalid && in_flight_q == 3'd0)
	// at most two words held inside
	`ASSERT_NEVER(a_depth, in_flight_q > 3'd2)
	// a word with no recomputation repeats position and delta
	`ASSERT_NEVER(a_hold_pos, m_tvalid && !m_tuser && (pos != last_pos_q || delta != last_delta_q))
	// a recomputed word's delta is the step from the last delivered position
	`ASSERT_NEVER(a_delta, m_tvalid && m_tuser && delta != pos - last_pos_q)

endmodule

bind endless_pot_position_decoder_top epd_checker u_epd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
